### design/aes_pkg.sv
// ---------------------------------------------------------------------------
// aes_pkg - shared types, constants and round functions
// S-box tables, GF(2^8) helpers, key size decode and the
// command/status structs between controller and datapath.
// ---------------------------------------------------------------------------
package aes_pkg;

    localparam int NUM_REGS  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int ROW_DEPTH = 15;
    localparam int ROW_AW    = $clog2(ROW_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd4;

    localparam logic [1:0] MODE_128    = 2'd0;
    localparam logic [1:0] MODE_192    = 2'd1;
    localparam logic [1:0] MODE_256    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1b;

    localparam logic [3:0] FWD_COEF [4] = '{4'd2, 4'd3, 4'd1, 4'd1};
    localparam logic [3:0] INV_COEF [4] = '{4'd14, 4'd11, 4'd13, 4'd9};

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_SUB_TABLE [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    typedef struct packed {
        logic              kx_start;
        logic              kx_step;
        logic [5:0]        kx_idx;
        logic              rk_rd;
        logic [ROW_AW-1:0] rk_addr;
        logic              blk_load;
        logic              add_only;
        logic              rnd;
        logic              rnd_last;
        logic              out_load;
    } aes_cmd_t;

    typedef struct packed {
        logic       cfg_wr;
        logic [1:0] key_mode;
        logic       dec;
    } aes_sts_t;

    function automatic logic [3:0] nk_of(input logic [1:0] mode);
        case (mode)
            MODE_128: return 4'd4;
            MODE_192: return 4'd6;
            default:  return 4'd8;
        endcase
    endfunction

    function automatic logic [3:0] nr_of(input logic [1:0] mode);
        case (mode)
            MODE_128: return 4'd10;
            MODE_192: return 4'd12;
            default:  return 4'd14;
        endcase
    endfunction

    // number of schedule words minus one
    function automatic logic [5:0] last_word_of(input logic [1:0] mode);
        case (mode)
            MODE_128: return 6'd43;
            MODE_192: return 6'd51;
            default:  return 6'd59;
        endcase
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] c);
        logic [7:0] x2, x4, x8;
        x2 = xt(a);
        x4 = xt(x2);
        x8 = xt(x4);
        return (c[0] ? a : 8'h00) ^ (c[1] ? x2 : 8'h00) ^
               (c[2] ? x4 : 8'h00) ^ (c[3] ? x8 : 8'h00);
    endfunction

    function automatic logic [31:0] word_subst(input logic [31:0] w);
        return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
    endfunction

    // byte n of the state sits at bits 127-8n downto 120-8n
    function automatic logic [127:0] state_subst(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            r[127-8*i -: 8] = inv ? INV_SUB_TABLE[s[127-8*i -: 8]] : FWD_SBOX[s[127-8*i -: 8]];
        end
        return r;
    endfunction

    function automatic logic [127:0] state_rotate(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        int src;
        int dst;
        r = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                src = ((c + k) & 3) * 4 + k;
                dst = c * 4 + k;
                if (inv)
                    r[127-8*src -: 8] = s[127-8*dst -: 8];
                else
                    r[127-8*dst -: 8] = s[127-8*src -: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] state_mix(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [7:0]   v;
        logic [3:0]   cf;
        r = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                v = 8'h00;
                for (int j = 0; j < 4; j++)
                begin
                    cf = inv ? INV_COEF[(j + 4 - k) & 3] : FWD_COEF[(j + 4 - k) & 3];
                    v  = v ^ gm(s[127-8*(c*4+j) -: 8], cf);
                end
                r[127-8*(c*4+k) -: 8] = v;
            end
        end
        return r;
    endfunction

endpackage

### design/aes_req_if.sv
// ---------------------------------------------------------------------------
// aes_req_if - block request channel
// Valid/ready channel carrying the command and one 16-byte block.
// ---------------------------------------------------------------------------
interface aes_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] block_upper;
    logic [63:0] block_lower;

    modport source (output valid, output command, output block_upper,
                    output block_lower, input ready);
    modport sink   (input valid, input command, input block_upper,
                    input block_lower, output ready);
endinterface

### design/aes_rsp_if.sv
// ---------------------------------------------------------------------------
// aes_rsp_if - block result channel
// Valid/ready channel carrying one 16-byte result.
// ---------------------------------------------------------------------------
interface aes_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_upper;
    logic [63:0] out_lower;

    modport source (output valid, output out_upper, output out_lower, input ready);
    modport sink   (input valid, input out_upper, input out_lower, output ready);
endinterface

### design/aes_cfg_if.sv
// ---------------------------------------------------------------------------
// aes_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface aes_cfg_if;
    import aes_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/aes_ram.sv
// ---------------------------------------------------------------------------
// aes_ram - generic simple dual-port ram
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### design/aes_dp.sv
// ---------------------------------------------------------------------------
// aes_dp - cipher datapath
// Key registers, key expansion unit, round-key ram, one shared
// round unit for both directions, and the result register.
// ---------------------------------------------------------------------------
module aes_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          blk_command,
    input  logic [63:0]                   blk_upper,
    input  logic [63:0]                   blk_lower,
    input  aes_pkg::aes_cmd_t             cmd,
    output aes_pkg::aes_sts_t             sts,
    output logic [63:0]                   res_upper,
    output logic [63:0]                   res_lower
);
    import aes_pkg::*;

    logic [1:0]   mode_reg;
    logic [63:0]  key_reg [4];
    logic [31:0]  win_reg [8];
    logic [95:0]  row_reg;
    logic [2:0]   modcnt_reg, modcnt_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [127:0] state_reg, state_next;
    logic         dec_reg;
    logic [127:0] res_reg;

    logic [3:0]   nk;
    logic [63:0]  kpart;
    logic [31:0]  kword, prev, far, sp, tw, word;
    logic         in_key;
    logic [127:0] rk, sh, mx, ak;

    assign nk = nk_of(mode_reg);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_128;
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE: mode_reg   <= cfg_data[1:0];
                REG_KEY0: key_reg[0] <= cfg_data;
                REG_KEY1: key_reg[1] <= cfg_data;
                REG_KEY2: key_reg[2] <= cfg_data;
                REG_KEY3: key_reg[3] <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign sts.cfg_wr   = cfg_we && ({1'b0, cfg_index} < 4'(NUM_REGS));
    assign sts.key_mode = mode_reg;
    assign sts.dec      = dec_reg;

    // key expansion: one schedule word per step
    assign kpart  = key_reg[cmd.kx_idx[2:1]];
    assign kword  = cmd.kx_idx[0] ? kpart[31:0] : kpart[63:32];
    assign in_key = cmd.kx_idx < {2'b00, nk};
    assign prev   = win_reg[0];
    assign sp     = word_subst(prev);

    always_comb
    begin
        case (nk)
            4'd4:    far = win_reg[3];
            4'd6:    far = win_reg[5];
            default: far = win_reg[7];
        endcase
        if (modcnt_reg == 3'd0)
            tw = {sp[23:0], sp[31:24]} ^ {rcon_reg, 24'h0};
        else if (nk == 4'd8 && modcnt_reg == 3'd4)
            tw = sp;
        else
            tw = prev;
        word = in_key ? kword : (far ^ tw);
    end

    always_comb
    begin
        modcnt_next = modcnt_reg;
        rcon_next   = rcon_reg;
        if (cmd.kx_start)
        begin
            modcnt_next = 3'd0;
            rcon_next   = RCON_FIRST;
        end
        else if (cmd.kx_step)
        begin
            modcnt_next = ({1'b0, modcnt_reg} == nk - 4'd1) ? 3'd0 : modcnt_reg + 3'd1;
            if (!in_key && modcnt_reg == 3'd0)
                rcon_next = xt(rcon_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        modcnt_reg <= modcnt_next;
        rcon_reg   <= rcon_next;
        if (cmd.kx_step)
        begin
            win_reg[0] <= word;
            for (int i = 1; i < 8; i++)
                win_reg[i] <= win_reg[i-1];
            row_reg <= {row_reg[63:0], word};
        end
    end

    aes_ram #(
        .WIDTH (128),
        .DEPTH (ROW_DEPTH)
    ) u_rk_ram (
        .clk   (clk),
        .we    (cmd.kx_step && cmd.kx_idx[1:0] == 2'b11),
        .waddr (cmd.kx_idx[5:2]),
        .wdata ({row_reg, word}),
        .re    (cmd.rk_rd),
        .raddr (cmd.rk_addr),
        .rdata (rk)
    );

    // shared round unit
    always_comb
    begin
        if (dec_reg)
            sh = state_subst(state_rotate(state_reg, 1'b1), 1'b1);
        else
            sh = state_rotate(state_subst(state_reg, 1'b0), 1'b0);
        ak = sh ^ rk;
        mx = state_mix(dec_reg ? ak : sh, dec_reg);

        state_next = state_reg;
        if (cmd.blk_load)
            state_next = {blk_upper, blk_lower};
        else if (cmd.add_only)
            state_next = state_reg ^ rk;
        else if (cmd.rnd)
        begin
            if (cmd.rnd_last)
                state_next = ak;
            else if (dec_reg)
                state_next = mx;
            else
                state_next = mx ^ rk;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        if (cmd.blk_load)
            dec_reg <= (blk_command == CMD_DECRYPT);
        if (cmd.out_load)
            res_reg <= state_reg;
    end

    assign res_upper = res_reg[127:64];
    assign res_lower = res_reg[63:0];
endmodule

### design/aes_ctl.sv
// ---------------------------------------------------------------------------
// aes_ctl - cipher controller
// Sequences key expansion, round-key reads and rounds, and owns
// the request/result handshakes and the schedule-valid flag.
// ---------------------------------------------------------------------------
module aes_ctl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  aes_pkg::aes_sts_t sts,
    output aes_pkg::aes_cmd_t cmd
);
    import aes_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_RUN    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       sched_reg, sched_next;
    logic [5:0] idx_reg, idx_next;
    logic [3:0] step_reg, step_next;
    logic       ovld_reg, ovld_next;
    logic [3:0] nr, nstep;

    assign nr    = nr_of(sts.key_mode);
    assign nstep = step_reg + 4'd1;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        sched_next = sched_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        ovld_next  = ovld_reg && !rsp_ready;
        req_ready  = (state_reg == ST_IDLE);
        cmd.kx_idx = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.blk_load = 1'b1;
                    if (sched_reg)
                        state_next = ST_FETCH;
                    else
                    begin
                        cmd.kx_start = 1'b1;
                        idx_next     = 6'd0;
                        state_next   = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND:
            begin
                cmd.kx_step = 1'b1;
                if (idx_reg == last_word_of(sts.key_mode))
                begin
                    sched_next = 1'b1;
                    state_next = ST_FETCH;
                end
                else
                    idx_next = idx_reg + 6'd1;
            end
            ST_FETCH:
            begin
                cmd.rk_rd   = 1'b1;
                cmd.rk_addr = sts.dec ? nr : 4'd0;
                step_next   = 4'd0;
                state_next  = ST_RUN;
            end
            ST_RUN:
            begin
                // round key for this step was read in the previous cycle
                cmd.add_only = (step_reg == 4'd0);
                cmd.rnd      = (step_reg != 4'd0);
                cmd.rnd_last = (step_reg == nr);
                cmd.rk_rd    = (step_reg != nr);
                cmd.rk_addr  = sts.dec ? nr - nstep : nstep;
                if (step_reg == nr)
                    state_next = ST_DONE;
                else
                    step_next = nstep;
            end
            ST_DONE:
            begin
                if (!ovld_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    ovld_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (sts.cfg_wr)
            sched_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sched_reg <= 1'b0;
            idx_reg   <= '0;
            step_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sched_reg <= sched_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            ovld_reg  <= ovld_next;
        end
    end

    assign rsp_valid = ovld_reg;
endmodule

### design/aes_block_cipher.sv
// an accepted block passes round-key fetch, key add, the rounds and the result load
// a stale key schedule is first expanded into 44, 52 or 60 words, one word per cycle
// a new item is taken only after the last one has left the shared round unit
// the result register frees the unit while a finished result waits
// reset clears config registers to zero and marks the key schedule stale
// ---------------------------------------------------------------------------
// aes_block_cipher - aes-128/192/256 single block cipher
// Controller plus datapath with a 15-row round-key ram.
// ---------------------------------------------------------------------------
module aes_block_cipher (
    input  logic  clk,
    input  logic  rst_n,
    aes_cfg_if.sink   cfg,
    aes_req_if.sink   req,
    aes_rsp_if.source rsp
);
    import aes_pkg::*;

    aes_cmd_t cmd;
    aes_sts_t sts;
    logic     cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    aes_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    aes_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .blk_command (req.command),
        .blk_upper   (req.block_upper),
        .blk_lower   (req.block_lower),
        .cmd         (cmd),
        .sts         (sts),
        .res_upper   (rsp.out_upper),
        .res_lower   (rsp.out_lower)
    );
endmodule

### design/aes_chk.sv
// ---------------------------------------------------------------------------
// aes_chk - port-level checker
// Watches the request and result channels of the cipher.
// ---------------------------------------------------------------------------
module aes_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] rsp_upper,
    input logic [63:0] rsp_lower
);
    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // no result can appear in the cycle right after an accept
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result too early");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_upper) && $stable(rsp_lower))
        else $error("result changed while stalled");
endmodule

bind aes_block_cipher aes_chk u_aes_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_upper (rsp.out_upper),
    .rsp_lower (rsp.out_lower)
);

### tb/sv/tb_aes_block_cipher.sv
// ---------------------------------------------------------------------------
// tb_aes_block_cipher - testbench for the aes single block cipher
// Writes key size and key registers while idle, sends encrypt and decrypt
// items under random valid and ready gaps, and checks every result against
// a behavioral aes model kept in the testbench.
// ---------------------------------------------------------------------------
module tb_aes_block_cipher;
    import aes_pkg::*;

    logic clk;
    logic rst_n;

    aes_cfg_if cfg ();
    aes_req_if req ();
    aes_rsp_if rsp ();

    aes_block_cipher uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
    } block_t;

    // testbench copy of registers and key schedule
    logic [63:0] key_regs [NUM_REGS];
    logic [31:0] sched_words [60];
    logic        sched_valid;

    block_t expected_blocks [$];
    int     error_count;
    int     result_count;
    int     item_count;
    bit     gaps_on;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [7:0] gf_x2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                acc = acc ^ x;
            x = gf_x2(x);
        end
        return acc;
    endfunction

    function automatic int words_in_key();
        int m;
        m = key_regs[REG_MODE][1:0];
        if (m > 2)
            m = 2;
        return 4 + 2 * m;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]],
                FWD_SBOX[w[7:0]]};
    endfunction

    function automatic void build_schedule();
        int nk;
        int total;
        logic [31:0] t;
        logic [7:0] rc;
        logic [63:0] part;
        nk = words_in_key();
        total = 4 * (nk + 7);
        rc = 8'h01;
        for (int i = 0; i < 60; i++)
            sched_words[i] = '0;
        for (int i = 0; i < nk; i++)
        begin
            part = key_regs[1 + i / 2];
            sched_words[i] = (i % 2) ? part[31:0] : part[63:32];
        end
        for (int i = nk; i < total; i++)
        begin
            t = sched_words[i - 1];
            if (i % nk == 0)
            begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_x2(rc);
            end
            else if (nk > 6 && i % nk == 4)
                t = sbox_word(t);
            sched_words[i] = sched_words[i - nk] ^ t;
        end
        sched_valid = 1'b1;
    endfunction

    function automatic void xor_round_key(ref logic [7:0] s [16], input int rnd);
        logic [31:0] w;
        for (int c = 0; c < 4; c++)
        begin
            w = sched_words[rnd * 4 + c];
            for (int r = 0; r < 4; r++)
                s[c * 4 + r] = s[c * 4 + r] ^ w[31 - 8 * r -: 8];
        end
    endfunction

    function automatic void shift_state(ref logic [7:0] s [16], input bit inv);
        logic [7:0] t [16];
        int src;
        t = s;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = ((c + r) % 4) * 4 + r;
                if (inv)
                    s[src] = t[c * 4 + r];
                else
                    s[c * 4 + r] = t[src];
            end
    endfunction

    function automatic void mix_state(ref logic [7:0] s [16], input bit inv);
        logic [7:0] a [4];
        logic [7:0] coef [4];
        logic [7:0] v;
        if (inv)
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
                a[k] = s[c * 4 + k];
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v = v ^ gf_times(a[k], coef[(k + 4 - r) % 4]);
                s[c * 4 + r] = v;
            end
        end
    endfunction

    function automatic void sub_state(ref logic [7:0] s [16], input bit inv);
        for (int i = 0; i < 16; i++)
            s[i] = inv ? INV_SUB_TABLE[s[i]] : FWD_SBOX[s[i]];
    endfunction

    function automatic block_t cipher_block(input logic cmd, input block_t din);
        logic [7:0] s [16];
        int rounds;
        block_t res;
        if (!sched_valid)
            build_schedule();
        rounds = words_in_key() + 6;
        for (int i = 0; i < 8; i++)
        begin
            s[i] = din.upper[63 - 8 * i -: 8];
            s[8 + i] = din.lower[63 - 8 * i -: 8];
        end
        if (cmd == CMD_ENCRYPT)
        begin
            xor_round_key(s, 0);
            for (int r = 1; r < rounds; r++)
            begin
                sub_state(s, 1'b0);
                shift_state(s, 1'b0);
                mix_state(s, 1'b0);
                xor_round_key(s, r);
            end
            sub_state(s, 1'b0);
            shift_state(s, 1'b0);
            xor_round_key(s, rounds);
        end
        else
        begin
            xor_round_key(s, rounds);
            for (int r = rounds - 1; r > 0; r--)
            begin
                shift_state(s, 1'b1);
                sub_state(s, 1'b1);
                xor_round_key(s, r);
                mix_state(s, 1'b1);
            end
            shift_state(s, 1'b1);
            sub_state(s, 1'b1);
            xor_round_key(s, 0);
        end
        for (int i = 0; i < 8; i++)
        begin
            res.upper[63 - 8 * i -: 8] = s[i];
            res.lower[63 - 8 * i -: 8] = s[8 + i];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    task automatic random_gap();
        if (gaps_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx < NUM_REGS)
        begin
            key_regs[idx] = (idx == REG_MODE) ? {62'b0, val[1:0]} : val;
            sched_valid = 1'b0;
        end
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic send_block(input logic cmd, input logic [63:0] up, input logic [63:0] lo);
        random_gap();
        req.valid       = 1'b1;
        req.command     = cmd;
        req.block_upper = up;
        req.block_lower = lo;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        expected_blocks.push_back(cipher_block(cmd, '{upper: up, lower: lo}));
        item_count++;
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    // wait for all results, then let the round unit settle before a write
    task automatic drain();
        while (expected_blocks.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic load_key(input logic [1:0] mode, input logic [63:0] k0,
                            input logic [63:0] k1, input logic [63:0] k2,
                            input logic [63:0] k3);
        drain();
        write_reg(REG_MODE, {62'b0, mode});
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
    endtask

    task automatic test_reset_key();
        send_block(CMD_ENCRYPT, '0, '0);
        send_block(CMD_DECRYPT, '1, '1);
    endtask

    task automatic test_standard_vectors();
        // fips-197 appendix c keys and plaintext
        load_key(MODE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        load_key(MODE_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, '1);
        send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(CMD_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        load_key(MODE_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(CMD_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    endtask

    task automatic test_extremes();
        // the unused size code behaves as a 256-bit key
        load_key(MODE_UNUSED, '1, '1, '1, '1);
        send_block(CMD_ENCRYPT, '1, '1);
        send_block(CMD_DECRYPT, '0, '0);
        send_block(CMD_ENCRYPT, 64'h8000000000000000, 64'h1);
        load_key(MODE_128, '0, '0, '0, '0);
        send_block(CMD_ENCRYPT, '1, '0);
        send_block(CMD_DECRYPT, '0, '1);
        // writing just one register re-expands the key
        drain();
        write_reg(REG_KEY1, 64'h5555aaaa5555aaaa);
        send_block(CMD_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        // out of range indexes are dropped and leave the schedule alone
        drain();
        write_reg(3'd5, '1);
        write_reg(3'd7, '1);
        send_block(CMD_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
    endtask

    task automatic test_random_traffic();
        logic [1:0] mode;
        for (int phase = 0; phase < 12; phase++)
        begin
            mode = 2'($urandom_range(0, 3));
            load_key(mode, rand64(), rand64(), rand64(), rand64());
            if (phase == 9)
                gaps_on = 1'b0;
            repeat (72)
                send_block(1'($urandom_range(0, 1)), rand64(), rand64());
        end
    endtask

    // output side: random stalls, check each item against the oldest expectation
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (gaps_on && $urandom_range(0, 5) == 0)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        block_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_blocks.size() == 0)
            begin
                $error("unexpected result %h %h", rsp.out_upper, rsp.out_lower);
                error_count++;
            end
            else
            begin
                want = expected_blocks.pop_front();
                result_count++;
                if (rsp.out_upper !== want.upper)
                begin
                    $error("out_upper expected %h actual %h", want.upper, rsp.out_upper);
                    error_count++;
                end
                if (rsp.out_lower !== want.lower)
                begin
                    $error("out_lower expected %h actual %h", want.lower, rsp.out_lower);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        error_count  = 0;
        result_count = 0;
        item_count   = 0;
        gaps_on      = 1'b1;
        sched_valid  = 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
            key_regs[i] = '0;
        rst_n           = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;
        req.valid       = 1'b0;
        req.command     = CMD_ENCRYPT;
        req.block_upper = '0;
        req.block_lower = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_key();
        test_standard_vectors();
        test_extremes();
        test_random_traffic();

        drain();
        if (expected_blocks.size() != 0)
        begin
            $error("%0d results never arrived", expected_blocks.size());
            error_count++;
        end
        $display("covered %0d items and %0d results over all key sizes, both directions",
                 item_count, result_count);
        if (error_count == 0)
            $display("tb_aes_block_cipher: done, clean");
        else
            $display("tb_aes_block_cipher: done, errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout with %0d results outstanding", expected_blocks.size());
        $display("tb_aes_block_cipher: done, errors");
        $finish;
    end

endmodule
